// ===== src/pose_dead_reckoning_defines.svh =====
// Assertion macros shared by the pose integrator checker.
// No dependencies.
`ifndef POSE_DEAD_RECKONING_DEFINES_SVH
`define POSE_DEAD_RECKONING_DEFINES_SVH
// Property that must hold on every clock edge outside reset.
`define PDR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property that must hold on every edge, reset included.
`define PDR_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== src/pdr_pkg.sv =====
// Package for the pose integrator: types, CORDIC table and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pdr_pkg;
    localparam int DEF_CORDIC_STEPS  = 16;
    localparam int DEF_POSITION_BITS = 32;
    localparam int TABLE_LEN         = 24;
    localparam logic [31:0] YAW_RESET = 32'h4000_0000;
    localparam logic signed [33:0] CORDIC_X0 = 34'sh026DD3B6A;

    typedef enum logic [3:0] {
        ST_IDLE, ST_C1_INIT, ST_C1_RUN, ST_C1_FIN, ST_MUL_X, ST_MUL_Y,
        ST_ACC, ST_C2_INIT, ST_C2_RUN, ST_C2_FIN, ST_OUT
    } t_state;

    typedef struct packed {
        logic load_vel;
        logic load_tick;
        logic cordic_init;
        logic cordic_half;
        logic cordic_step;
        logic cordic_fin1;
        logic cordic_fin2;
        logic mul_x;
        logic mul_y;
        logic acc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic cordic_done;
    } t_status;

    function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
        logic signed [33:0] r;
        case (i)
            5'd0:  r = 34'sh020000000; 5'd1:  r = 34'sh012E4051E;
            5'd2:  r = 34'sh009FB385B; 5'd3:  r = 34'sh0051111D4;
            5'd4:  r = 34'sh0028B0D43; 5'd5:  r = 34'sh00145D7E1;
            5'd6:  r = 34'sh000A2F61E; 5'd7:  r = 34'sh000517C55;
            5'd8:  r = 34'sh00028BE53; 5'd9:  r = 34'sh000145F2F;
            5'd10: r = 34'sh0000A2F98; 5'd11: r = 34'sh0000517CC;
            5'd12: r = 34'sh000028BE6; 5'd13: r = 34'sh0000145F3;
            5'd14: r = 34'sh00000A2F9; 5'd15: r = 34'sh00000517C;
            5'd16: r = 34'sh0000028BE; 5'd17: r = 34'sh00000145F;
            5'd18: r = 34'sh000000A2F; 5'd19: r = 34'sh000000517;
            5'd20: r = 34'sh00000028B; 5'd21: r = 34'sh000000145;
            5'd22: r = 34'sh0000000A2; 5'd23: r = 34'sh000000051;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== src/pdr_ctrl.sv =====
// Controller state machine for the pose integrator.
// Depends on pdr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pdr_ctrl import pdr_pkg::*; (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_valid,
    input  wire      i_mode,
    output logic     o_stall,
    output logic     o_valid,
    input  wire      i_stall,
    input  t_status  i_status,
    output t_cmd     o_cmd
);
    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   w_accept;

    // Accept only when idle
    assign o_stall  = (r_state != ST_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign o_valid  = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // Load a velocity in idle; sequence a tick through both rotations and the multiplies
    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        o_cmd   = '0;
        if (r_valid && !i_stall) n_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_mode) begin
                        o_cmd.load_tick = 1'b1;
                        n_state = ST_C1_INIT;
                    end else o_cmd.load_vel = 1'b1;
                end
            end
            ST_C1_INIT: begin
                o_cmd.cordic_init = 1'b1;
                n_state = ST_C1_RUN;
            end
            ST_C1_RUN: begin
                o_cmd.cordic_step = 1'b1;
                if (i_status.cordic_done) n_state = ST_C1_FIN;
            end
            ST_C1_FIN: begin
                o_cmd.cordic_fin1 = 1'b1;
                n_state = ST_MUL_X;
            end
            ST_MUL_X: begin
                o_cmd.mul_x = 1'b1;
                n_state = ST_MUL_Y;
            end
            ST_MUL_Y: begin
                o_cmd.mul_y = 1'b1;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = ST_C2_INIT;
            end
            ST_C2_INIT: begin
                o_cmd.cordic_init = 1'b1;
                o_cmd.cordic_half = 1'b1;
                n_state = ST_C2_RUN;
            end
            ST_C2_RUN: begin
                o_cmd.cordic_step = 1'b1;
                if (i_status.cordic_done) n_state = ST_C2_FIN;
            end
            ST_C2_FIN: begin
                o_cmd.cordic_fin2 = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                // Wait for the output register to free up
                if (!r_valid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== src/pdr_datapath.sv =====
// Datapath of the pose integrator: pose registers, iterative CORDIC and
// the shared multiplier. Depends on pdr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pdr_datapath import pdr_pkg::*; #(
    parameter int CORDIC_STEPS  = DEF_CORDIC_STEPS,
    parameter int POSITION_BITS = DEF_POSITION_BITS
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  wire signed [15:0]  i_speed,
    input  wire signed [15:0]  i_turn_rate,
    input  wire        [15:0]  i_elapsed,
    output logic signed [31:0] o_x_position,
    output logic signed [31:0] o_y_position,
    output logic signed [15:0] o_yaw_angle,
    output logic signed [15:0] o_quat_real,
    output logic signed [15:0] o_quat_yaw_part
);
    localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int PB    = POSITION_BITS;

    logic signed [15:0] r_speed, r_turn;
    logic        [15:0] r_elapsed;
    logic [PB-1:0]      r_x, r_y;
    logic [31:0]        r_yaw;
    logic signed [33:0] r_cx, r_cy, r_cz;
    logic [4:0]         r_step;
    logic               r_flip;
    logic signed [15:0] r_cos, r_sin;
    logic signed [32:0] r_ve;
    logic signed [48:0] r_px, r_py;
    logic signed [15:0] n_cres, n_sres;

    // Latch velocity on a mode-0 transaction; elapsed time on a tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= '0;
            r_turn  <= '0;
        end else if (i_cmd.load_vel) begin
            r_speed <= i_speed;
            r_turn  <= i_turn_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_tick) begin
            r_elapsed <= i_elapsed;
        end
    end

    // Fold the CORDIC angle into the right half plane
    logic [31:0] w_ang, w_fold;
    logic        w_flip;
    assign w_ang  = i_cmd.cordic_half ? {r_yaw[31], r_yaw[31:1]} : r_yaw;
    assign w_flip = (w_ang[31:30] == 2'b01) || (w_ang[31:30] == 2'b10);
    assign w_fold = w_flip ? (w_ang + 32'h8000_0000) : w_ang;

    // One CORDIC rotation per cycle
    logic signed [33:0] w_dx, w_dy, w_at;
    assign w_dx = r_cy >>> r_step;
    assign w_dy = r_cx >>> r_step;
    assign w_at = atan_entry(r_step);
    assign o_status.cordic_done = (r_step == 5'(STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.cordic_init) begin
            r_cx   <= CORDIC_X0;
            r_cy   <= '0;
            r_cz   <= 34'(signed'(w_fold));
            r_step <= '0;
            r_flip <= w_flip;
        end else if (i_cmd.cordic_step) begin
            if (!r_cz[33]) begin
                r_cx <= r_cx - w_dx;
                r_cy <= r_cy + w_dy;
                r_cz <= r_cz - w_at;
            end else begin
                r_cx <= r_cx + w_dx;
                r_cy <= r_cy - w_dy;
                r_cz <= r_cz + w_at;
            end
            r_step <= r_step + 5'd1;
        end
    end

    // Round to Q1.14, clamp, undo the fold
    function automatic logic signed [15:0] to_q14(input logic signed [33:0] v,
                                                  input logic flip);
        logic signed [33:0] s;
        logic signed [15:0] c;
        s = (v + 34'sd32768) >>> 16;
        if (s > 34'sd16384) c = 16'sd16384;
        else if (s < -34'sd16384) c = -16'sd16384;
        else c = s[15:0];
        return flip ? -c : c;
    endfunction

    assign n_cres = to_q14(r_cx, r_flip);
    assign n_sres = to_q14(r_cy, r_flip);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cordic_fin1 || i_cmd.cordic_fin2) begin
            r_cos <= n_cres;
            r_sin <= n_sres;
        end
        if (i_cmd.cordic_fin1) begin
            r_ve <= 33'(r_speed * $signed({1'b0, r_elapsed}));
        end
    end

    // Shared multiplier: speed*elapsed by cos, then by sin
    logic signed [48:0] w_prod;
    assign w_prod = 49'(r_ve * (i_cmd.mul_x ? r_cos : r_sin));
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_x) r_px <= w_prod;
        if (i_cmd.mul_y) r_py <= w_prod;
    end

    // Accumulate position and heading
    logic signed [48:0] w_dxp, w_dyp;
    logic signed [32:0] w_dyaw;
    assign w_dxp  = (r_px + 49'sd8388608) >>> 24;
    assign w_dyp  = (r_py + 49'sd8388608) >>> 24;
    assign w_dyaw = 33'(r_turn * $signed({1'b0, r_elapsed}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x   <= '0;
            r_y   <= '0;
            r_yaw <= YAW_RESET;
        end else if (i_cmd.acc) begin
            r_x   <= r_x + PB'(w_dxp);
            r_y   <= r_y + PB'(w_dyp);
            r_yaw <= r_yaw + w_dyaw[31:0];
        end
    end

    // Output register
    logic signed [63:0] w_xs, w_ys;
    assign w_xs = 64'(signed'(r_x));
    assign w_ys = 64'(signed'(r_y));
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_x_position    <= w_xs[31:0];
            o_y_position    <= w_ys[31:0];
            o_yaw_angle     <= r_yaw[31:16];
            o_quat_real     <= r_cos;
            o_quat_yaw_part <= r_sin;
        end
    end
endmodule
`default_nettype wire

// ===== src/pose_dead_reckoning.sv =====
// Pose integrator top level: controller plus datapath.
// Depends on pdr_pkg, pdr_ctrl and pdr_datapath.
//
// A velocity transaction (mode 0) is taken without stalling the input. A tick transaction
// (mode 1) runs the controller through both rotations and the multiplies:
// one CORDIC unit that rotates one step a cycle is run twice, for the old
// heading and for the new half heading, and one multiplier forms both
// position increments. The result sits in an output register; the input
// is stalled while a tick is in progress.
`timescale 1ns / 1ps
`default_nettype none
module pose_dead_reckoning import pdr_pkg::*; #(
    parameter int CORDIC_STEPS  = DEF_CORDIC_STEPS,
    parameter int POSITION_BITS = DEF_POSITION_BITS
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire                i_mode,
    input  wire signed [15:0]  i_speed,
    input  wire signed [15:0]  i_turn_rate,
    input  wire        [15:0]  i_elapsed,
    output logic               o_valid,
    input  wire                i_stall,
    output logic signed [31:0] o_x_position,
    output logic signed [31:0] o_y_position,
    output logic signed [15:0] o_yaw_angle,
    output logic signed [15:0] o_quat_real,
    output logic signed [15:0] o_quat_yaw_part
);
    t_cmd    w_cmd;
    t_status w_status;

    pdr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_mode(i_mode),
        .o_stall(o_stall), .o_valid(o_valid), .i_stall(i_stall),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    pdr_datapath #(.CORDIC_STEPS(CORDIC_STEPS), .POSITION_BITS(POSITION_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_status(w_status),
        .i_speed(i_speed), .i_turn_rate(i_turn_rate), .i_elapsed(i_elapsed),
        .o_x_position(o_x_position), .o_y_position(o_y_position),
        .o_yaw_angle(o_yaw_angle), .o_quat_real(o_quat_real),
        .o_quat_yaw_part(o_quat_yaw_part)
    );
endmodule
`default_nettype wire

// ===== src/pdr_checker.sv =====
// Port-level checker for the pose integrator, bound to the top level.
// Depends on pose_dead_reckoning_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "pose_dead_reckoning_defines.svh"
module pdr_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        o_stall,
    input wire        i_mode,
    input wire        o_valid,
    input wire        i_stall,
    input wire [15:0] o_quat_real,
    input wire [15:0] o_quat_yaw_part
);
    // A tick transaction blocks further input on the next cycle
    `PDR_ASSERT(a_tick_stalls, i_clk, i_rst_n, (i_valid && !o_stall && i_mode) |=> o_stall, "tick not stalled")
    // A velocity transaction leaves the input open
    `PDR_ASSERT(a_vel_open, i_clk, i_rst_n, (i_valid && !o_stall && !i_mode) |=> !o_stall, "velocity stalled")
    // Held result keeps its payload
    `PDR_ASSERT(a_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_quat_real) && $stable(o_quat_yaw_part)), "result changed")
    // Reset leaves no result pending
    `PDR_ASSERT_ALWAYS(a_reset, i_clk, !$past(i_rst_n) |-> !o_valid, "valid after reset")
endmodule
bind pose_dead_reckoning pdr_checker u_pdr_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .i_mode(i_mode), .o_valid(o_valid), .i_stall(i_stall),
    .o_quat_real(o_quat_real), .o_quat_yaw_part(o_quat_yaw_part)
);
`default_nettype wire

// ===== tb/pose_dead_reckoning_test.sv =====
// Testbench for the dead-reckoning pose integrator: directed and random velocity and tick
// transactions, checked against a bit-true model of the CORDIC and position arithmetic.
// Depends on pdr_pkg and pose_dead_reckoning.
`timescale 1ns / 1ps
module pose_dead_reckoning_test;
    import pdr_pkg::*;

    localparam int  STEPS       = DEF_CORDIC_STEPS;
    localparam int  POS_BITS    = DEF_POSITION_BITS;
    localparam int  CYCLE_LIMIT = 2000000;
    localparam bit  MODE_VEL    = 1'b0;
    localparam bit  MODE_TICK   = 1'b1;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] yaw;
        logic signed [15:0] qr;
        logic signed [15:0] qy;
    } t_pose;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               in_mode = 1'b0;
    logic signed [15:0] in_speed = '0;
    logic signed [15:0] in_turn = '0;
    logic        [15:0] in_elapsed = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] out_x, out_y;
    logic signed [15:0] out_yaw, out_qr, out_qy;

    // model state
    logic signed [15:0] speed_q, turn_q;
    logic        [63:0] x_acc, y_acc;
    logic        [31:0] yaw_acc;

    t_pose pose_queue[$];
    int    fail_count = 0;
    int    cycle_count = 0;
    bit    idle_enable = 1'b1;
    bit    done = 1'b0;

    pose_dead_reckoning DUT (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_mode(in_mode), .i_speed(in_speed), .i_turn_rate(in_turn),
        .i_elapsed(in_elapsed), .o_valid(out_valid), .i_stall(out_stall),
        .o_x_position(out_x), .o_y_position(out_y), .o_yaw_angle(out_yaw),
        .o_quat_real(out_qr), .o_quat_yaw_part(out_qy)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic longint atan_step(int i);
        longint t[24] = '{
            64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
            64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
            64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
            64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
            64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
            64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};
        return t[i];
    endfunction

    function automatic longint clamp_q14(longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    // Rotate from the unit vector to the given binary angle.
    task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
        bit     flip;
        longint cx, cy, z, dx, dy;
        flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
        if (flip) ang = ang + 32'h8000_0000;
        cx = 64'h26DD3B6A;
        cy = 0;
        z = longint'(signed'(ang));
        for (int i = 0; i < STEPS && i < 24; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (z >= 0) begin
                cx -= dx; cy += dy; z -= atan_step(i);
            end else begin
                cx += dx; cy -= dy; z += atan_step(i);
            end
        end
        c = clamp_q14((cx + 32768) >>> 16);
        s = clamp_q14((cy + 32768) >>> 16);
        if (flip) begin
            c = -c; s = -s;
        end
    endtask

    function automatic logic [31:0] pos_word(logic [63:0] p);
        logic [63:0] q;
        q = p;
        if (p[POS_BITS-1]) q = p | ~((64'd1 << POS_BITS) - 1);
        return q[31:0];
    endfunction

    task automatic reset_pose();
        speed_q = '0; turn_q = '0; x_acc = '0; y_acc = '0; yaw_acc = YAW_RESET;
    endtask

    // Integrate one transaction; a tick queues the pose it reports.
    task automatic integrate_pose(bit mode, logic signed [15:0] spd,
                                  logic signed [15:0] trn, logic [15:0] el);
        longint c, s, hc, hs, v, e, dx, dy;
        logic [31:0] half;
        t_pose p;
        if (mode == MODE_VEL) begin
            speed_q = spd; turn_q = trn;
            return;
        end
        e = longint'(el);
        v = longint'(speed_q);
        rotate(yaw_acc, c, s);
        dx = (v * e * c + (64'sd1 <<< 23)) >>> 24;
        dy = (v * e * s + (64'sd1 <<< 23)) >>> 24;
        x_acc = (x_acc + dx) & ((64'd1 << POS_BITS) - 1);
        y_acc = (y_acc + dy) & ((64'd1 << POS_BITS) - 1);
        yaw_acc = yaw_acc + 32'(longint'(turn_q) * e);
        half = {yaw_acc[31], yaw_acc[31:1]};
        rotate(half, hc, hs);
        p.x = pos_word(x_acc);
        p.y = pos_word(y_acc);
        p.yaw = yaw_acc[31:16];
        p.qr = 16'(hc);
        p.qy = 16'(hs);
        pose_queue.push_back(p);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Send one transaction, with an occasional random gap ahead of it.
    task automatic send_item(bit mode, logic signed [15:0] spd,
                             logic signed [15:0] trn, logic [15:0] el);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_mode <= mode; in_speed <= spd; in_turn <= trn; in_elapsed <= el;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        integrate_pose(mode, spd, trn, el);
    endtask

    task automatic send_random(bit tick_bias);
        bit mode;
        logic [15:0] el;
        mode = tick_bias ? ($urandom_range(0, 3) != 0) : 1'($urandom);
        case ($urandom_range(0, 3))
            0: el = 16'hFFFF;
            1: el = 16'($urandom_range(0, 15));
            default: el = 16'($urandom);
        endcase
        send_item(mode, 16'($urandom), 16'($urandom), el);
    endtask

    // Drop valid straight after the last acceptance, then wait for the results.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pose_queue.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // Extremes of speed, turn rate and elapsed time; a velocity ignores elapsed.
    task automatic test_directed();
        send_item(MODE_TICK, 16'sh7FFF, 16'sh7FFF, 16'hFFFF);
        send_item(MODE_VEL, 16'sh7FFF, 16'sh7FFF, 16'hFFFF);
        send_item(MODE_TICK, 16'sh0000, 16'sh8000, 16'hFFFF);
        send_item(MODE_TICK, 16'sh0000, 16'sh0000, 16'h0000);
        send_item(MODE_VEL, 16'sh8000, 16'sh8000, 16'h0000);
        send_item(MODE_TICK, 16'sh1234, 16'sh5678, 16'hFFFF);
        send_item(MODE_TICK, 16'sh0000, 16'sh0000, 16'h0001);
        send_item(MODE_VEL, 16'sh7FFF, 16'sh4000, 16'h5555);
        for (int i = 0; i < 8; i++) send_item(MODE_TICK, 16'sh0, 16'sh0, 16'h8000);
        send_item(MODE_VEL, -16'sd1, 16'sd1, 16'h0);
        send_item(MODE_TICK, 16'sh0, 16'sh0, 16'hAAAA);
        send_item(MODE_VEL, 16'sh0, 16'sh0, 16'h0);
        send_item(MODE_TICK, 16'sh0, 16'sh0, 16'h5555);
        drain_results();
    endtask

    // Long runs at full speed to build up large position values.
    task automatic test_overflow();
        send_item(MODE_VEL, 16'sh7FFF, 16'sh0001, 16'h0);
        for (int i = 0; i < 200; i++) send_item(MODE_TICK, 16'sh0, 16'sh0, 16'hFFFF);
        drain_results();
    endtask

    task automatic test_random();
        for (int i = 0; i < 1500; i++) send_random(1'b1);
        drain_results();
    endtask

    // Closing stretch without idling on either side.
    task automatic test_streaming();
        idle_enable = 1'b0;
        for (int i = 0; i < 200; i++) send_random(1'b0);
        drain_results();
    endtask

    // Stall the result side in random bursts.
    initial begin
        forever begin
            @(posedge clk);
            if (idle_enable && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // Compare each accepted pose with the oldest expectation.
    always @(posedge clk) begin
        t_pose want;
        if (rst_n && out_valid && !out_stall) begin
            if (pose_queue.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = pose_queue.pop_front();
                if (out_x !== want.x) report_mismatch("x_position", out_x, want.x);
                if (out_y !== want.y) report_mismatch("y_position", out_y, want.y);
                if (out_yaw !== want.yaw) report_mismatch("yaw_angle", out_yaw, want.yaw);
                if (out_qr !== want.qr) report_mismatch("quat_real", out_qr, want.qr);
                if (out_qy !== want.qy)
                    report_mismatch("quat_yaw_part", out_qy, want.qy);
            end
        end
    end

    // Abort a hung run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT && !done) begin
            $display("pose_dead_reckoning_test: FAIL");
            $finish;
        end
    end

    initial begin
        reset_pose();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overflow();
        test_random();
        test_streaming();
        done = 1'b1;
        if (fail_count == 0 && pose_queue.size() == 0) begin
            $display("pose_dead_reckoning_test: PASS");
        end else begin
            $display("pose_dead_reckoning_test: FAIL");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/pdr_pkg.sv
src/pdr_ctrl.sv
src/pdr_datapath.sv
src/pose_dead_reckoning.sv
src/pdr_checker.sv
tb/pose_dead_reckoning_test.sv
